// ----- hdl/pkl_pkg.sv -----
// shared types and codes for the packed key list engine
// no dependencies; used by pkl_cell, packed_key_list_engine, pkl_checker and the testbench
package pkl_pkg;

  localparam int KEY_W    = 31;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;
  // wide enough for an index or a fill count at the largest list depth
  localparam int SEL_W    = 9;

  localparam logic [CMD_W-1:0] CMD_CHECK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic             shift_en;  // entries at or after sel take their neighbor
    logic             ins_en;    // entry at fill takes the key
    logic [SEL_W-1:0] sel;
    logic [SEL_W-1:0] fill;
  } cell_ctl_t;

endpackage

// ----- hdl/pkl_cell.sv -----
// one list entry: holds a key, compares it and hands it up the chain
// depends on pkl_pkg
module pkl_cell #(
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cmp_en,
  input  logic [pkl_pkg::KEY_W-1:0] key,
  input  pkl_pkg::cell_ctl_t       ctl,
  input  logic [pkl_pkg::KEY_W-1:0] nbr_entry,
  output logic [pkl_pkg::KEY_W-1:0] entry,
  output logic                     match
);

  logic [pkl_pkg::KEY_W-1:0] entry_r, entry_nxt;
  logic                      match_r, match_nxt;
  logic [pkl_pkg::SEL_W-1:0] my_idx;

  assign my_idx = pkl_pkg::SEL_W'(IDX);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.shift_en && (my_idx >= ctl.sel)) begin
      entry_nxt = nbr_entry;
    end else if (ctl.ins_en && (my_idx == ctl.fill)) begin
      entry_nxt = key;
    end
  end

  // empty entries never match since the key is checked nonzero
  assign match_nxt = cmp_en ? ((key != '0) && (entry_r == key)) : match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
      match_r <= 1'b0;
    end else begin
      entry_r <= entry_nxt;
      match_r <= match_nxt;
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

// ----- hdl/pkl_hit_enc.sv -----
// turns the per-cell match bits into a hit flag and a hit index
// depends on nothing but its parameters
module pkl_hit_enc #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic [DEPTH-1:0] match,
  output logic             hit,
  output logic [IW-1:0]    idx
);

  // at most one bit is set, so an or of the indexes is the index
  always_comb begin
    idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

  assign hit = |match;

endmodule

// ----- hdl/packed_key_list_engine.sv -----
// top level of the packed key list engine: control, fill count, result register
// depends on pkl_pkg, pkl_cell, pkl_hit_enc
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_cmd[1:0], in_key[30:0]
//  out     | output    | out_valid/out_stall| out_status[1:0], out_position[4:0]
//
// for each item every cell compares its entry, the hit is encoded, then the engine acts
// (insert, shift the chain by one cell, or nothing) and loads the result register
// a new item is taken once the act cycle has loaded the result register
// out_stall holds the act cycle only while a previous result is still waiting
// synchronous reset clears every entry, the fill count and the result valid flag
module packed_key_list_engine #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pkl_pkg::CMD_W-1:0]     in_cmd,
  input  logic [pkl_pkg::KEY_W-1:0]     in_key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pkl_pkg::STATUS_W-1:0]  out_status,
  output logic [pkl_pkg::POS_W-1:0]     out_position
);

  localparam int IW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FIND = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [pkl_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [pkl_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [CW-1:0]                fill_r, fill_nxt;
  logic                         hit_r, hit_nxt;
  logic [IW-1:0]                hit_idx_r, hit_idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [pkl_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [pkl_pkg::POS_W-1:0]    pos_r, pos_nxt;

  logic                         in_xfer;
  logic                         exec_go;
  logic                         full;
  logic [CW-1:0]                hit_pos;
  logic [LIST_DEPTH-1:0]        match;
  logic                         enc_hit;
  logic [IW-1:0]                enc_idx;
  logic [pkl_pkg::KEY_W-1:0]    ent [LIST_DEPTH];
  logic [pkl_pkg::KEY_W-1:0]    cmp_key;
  pkl_pkg::cell_ctl_t           ctl;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign exec_go  = (state_r == S_EXEC) && (!out_valid_r || !out_stall);
  assign full     = (fill_r == CW'(LIST_DEPTH));
  assign hit_pos  = CW'(hit_idx_r) + CW'(1);

  // insert writes key_r; the compare uses the incoming key
  assign cmp_key = in_xfer ? in_key : key_r;

  // chain of cells
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [pkl_pkg::KEY_W-1:0] nbr;
    if (i == LIST_DEPTH - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = ent[i+1];
    end
    pkl_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmp_en   (in_xfer),
      .key      (cmp_key),
      .ctl      (ctl),
      .nbr_entry(nbr),
      .entry    (ent[i]),
      .match    (match[i])
    );
  end

  pkl_hit_enc #(
    .DEPTH(LIST_DEPTH),
    .IW   (IW)
  ) u_enc (
    .match(match),
    .hit  (enc_hit),
    .idx  (enc_idx)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    fill_nxt      = fill_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    pos_nxt       = pos_r;
    ctl           = '0;
    ctl.sel       = pkl_pkg::SEL_W'(hit_idx_r);
    ctl.fill      = pkl_pkg::SEL_W'(fill_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt   = in_cmd;
          key_nxt   = in_key;
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        hit_nxt     = enc_hit;
        hit_idx_nxt = enc_idx;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) begin
          status_nxt    = pkl_pkg::ST_NOT_FOUND;
          pos_nxt       = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          case (cmd_r)
            pkl_pkg::CMD_CHECK: begin
              if (hit_r) begin
                status_nxt = pkl_pkg::ST_FOUND;
                pos_nxt    = pkl_pkg::POS_W'(hit_pos);
              end
            end
            pkl_pkg::CMD_PUT: begin
              if (hit_r) begin
                status_nxt = pkl_pkg::ST_FOUND;
                pos_nxt    = pkl_pkg::POS_W'(hit_pos);
              end else if (key_r != '0) begin
                if (full) begin
                  status_nxt = pkl_pkg::ST_FULL;
                end else begin
                  ctl.ins_en = 1'b1;
                  fill_nxt   = fill_r + CW'(1);
                  status_nxt = pkl_pkg::ST_INSERTED;
                end
              end
            end
            pkl_pkg::CMD_DEL: begin
              if (hit_r) begin
                ctl.shift_en = 1'b1;
                fill_nxt     = fill_r - CW'(1);
                status_nxt   = pkl_pkg::ST_FOUND;
                pos_nxt      = pkl_pkg::POS_W'(hit_pos);
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    hit_idx_r <= hit_idx_nxt;
    status_r  <= status_nxt;
    pos_r     <= pos_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_position = pos_r;

  // keys are unique in the list, so at most one cell matches
  a_match_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIND) |-> $onehot0(match))
    else $error("more than one cell matched the key");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(LIST_DEPTH))
    else $error("fill count beyond list depth");

  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    !full |-> (ent[fill_r[IW-1:0]] == '0))
    else $error("entry at fill count is not empty");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_en |-> (!full && !hit_r))
    else $error("insert into a full list or of a present key");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> (out_valid && (state_r == S_IDLE)))
    else $error("act cycle did not load a result");

endmodule

// ----- sim/pkl_checker.sv -----
// result checker for the packed key list engine: tracks the key list, predicts
// each result and compares it with the result channel
// depends on pkl_pkg
module pkl_checker #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [pkl_pkg::CMD_W-1:0]     in_cmd,
  input  logic [pkl_pkg::KEY_W-1:0]     in_key,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [pkl_pkg::STATUS_W-1:0]  out_status,
  input  logic [pkl_pkg::POS_W-1:0]     out_position,
  output int                            errors,
  output int                            outstanding,
  output int                            n_found,
  output int                            n_inserted,
  output int                            n_full,
  output int                            n_missed
);

  typedef struct packed {
    logic [pkl_pkg::STATUS_W-1:0] status;
    logic [pkl_pkg::POS_W-1:0]    position;
  } list_result_t;

  logic [pkl_pkg::KEY_W-1:0] key_store [LIST_DEPTH];
  list_result_t              expected_results [$];

  initial begin
    errors      = 0;
    outstanding = 0;
    n_found     = 0;
    n_inserted  = 0;
    n_full      = 0;
    n_missed    = 0;
  end

  // applies one command to the tracked list and returns the result it gives
  function automatic list_result_t apply_command(input logic [pkl_pkg::CMD_W-1:0] cmd,
                                                 input logic [pkl_pkg::KEY_W-1:0] key);
    list_result_t res;
    int           filled;
    int           hit;
    int           i;
    res.status   = pkl_pkg::ST_NOT_FOUND;
    res.position = '0;
    filled = 0;
    while (filled < LIST_DEPTH && key_store[filled] != '0)
      filled++;
    // search only the filled prefix; key zero never matches
    hit = LIST_DEPTH;
    if (key != '0) begin
      for (i = filled - 1; i >= 0; i--)
        if (key_store[i] == key)
          hit = i;
    end
    case (cmd)
      pkl_pkg::CMD_CHECK: begin
        if (hit < LIST_DEPTH) begin
          res.status   = pkl_pkg::ST_FOUND;
          res.position = pkl_pkg::POS_W'(hit + 1);
        end
      end
      pkl_pkg::CMD_PUT: begin
        if (hit < LIST_DEPTH) begin
          res.status   = pkl_pkg::ST_FOUND;
          res.position = pkl_pkg::POS_W'(hit + 1);
        end else if (key != '0) begin
          if (filled >= LIST_DEPTH) begin
            res.status = pkl_pkg::ST_FULL;
          end else begin
            key_store[filled] = key;
            res.status        = pkl_pkg::ST_INSERTED;
          end
        end
      end
      pkl_pkg::CMD_DEL: begin
        if (hit < LIST_DEPTH) begin
          for (i = hit + 1; i < LIST_DEPTH; i++)
            key_store[i-1] = key_store[i];
          key_store[LIST_DEPTH-1] = '0;
          res.status   = pkl_pkg::ST_FOUND;
          res.position = pkl_pkg::POS_W'(hit + 1);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    list_result_t seen;
    list_result_t want;
    if (!rst_n) begin
      foreach (key_store[i])
        key_store[i] = '0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen.status   = out_status;
        seen.position = out_position;
        case (seen.status)
          pkl_pkg::ST_FOUND:    n_found++;
          pkl_pkg::ST_INSERTED: n_inserted++;
          pkl_pkg::ST_FULL:     n_full++;
          default:              n_missed++;
        endcase
        if (expected_results.size() == 0) begin
          errors++;
          $error("result transfer with nothing expected: status %0d position %0d",
                 seen.status, seen.position);
        end else begin
          want = expected_results.pop_front();
          if (seen.status !== want.status) begin
            errors++;
            $error("status mismatch: expected %0d, got %0d", want.status, seen.status);
          end
          if (seen.position !== want.position) begin
            errors++;
            $error("position mismatch: expected %0d, got %0d",
                   want.position, seen.position);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(apply_command(in_cmd, in_key));
    end
    outstanding = expected_results.size();
  end

endmodule

// ----- sim/packed_key_list_engine_test.sv -----
// testbench top for the packed key list engine: clock, reset, command stimulus,
// receiver stalls and the verdict
// depends on pkl_pkg, packed_key_list_engine and pkl_checker
module packed_key_list_engine_test;

  localparam int LIST_DEPTH  = 16;
  localparam int KEY_POOL    = 24;
  localparam int HOLD_CYCLES = 80;
  localparam logic [pkl_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [pkl_pkg::KEY_W-1:0] KEY_MAX    = {pkl_pkg::KEY_W{1'b1}};

  logic                         clk          = 1'b0;
  logic                         rst_n        = 1'b0;
  logic                         in_valid     = 1'b0;
  logic                         in_stall;
  logic [pkl_pkg::CMD_W-1:0]    in_cmd       = pkl_pkg::CMD_CHECK;
  logic [pkl_pkg::KEY_W-1:0]    in_key       = '0;
  logic                         out_valid;
  logic                         out_stall    = 1'b0;
  logic [pkl_pkg::STATUS_W-1:0] out_status;
  logic [pkl_pkg::POS_W-1:0]    out_position;

  int errors;
  int outstanding;
  int n_found;
  int n_inserted;
  int n_full;
  int n_missed;

  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int sent      = 0;

  logic [pkl_pkg::KEY_W-1:0] key_pool [KEY_POOL];

  always #2 clk = ~clk;

  packed_key_list_engine #(
    .LIST_DEPTH(LIST_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_key(in_key),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_position(out_position)
  );

  pkl_checker #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_key(in_key),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_position(out_position),
    .errors(errors),
    .outstanding(outstanding),
    .n_found(n_found),
    .n_inserted(n_inserted),
    .n_full(n_full),
    .n_missed(n_missed)
  );

  // receiver: random stalls, or a long hold once one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_item(input logic [pkl_pkg::CMD_W-1:0] cmd,
                           input logic [pkl_pkg::KEY_W-1:0] key);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_key   <= key;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sent++;
  endtask

  // mostly keys from a small pool so the list fills, hits and runs full
  task automatic send_random();
    int                        pick;
    logic [pkl_pkg::CMD_W-1:0] cmd;
    logic [pkl_pkg::KEY_W-1:0] key;
    pick = $urandom_range(99);
    if (pick < 3)
      cmd = CMD_UNUSED;
    else if (pick < 45)
      cmd = pkl_pkg::CMD_PUT;
    else if (pick < 72)
      cmd = pkl_pkg::CMD_CHECK;
    else
      cmd = pkl_pkg::CMD_DEL;
    pick = $urandom_range(99);
    if (pick < 4)
      key = '0;
    else if (pick < 12)
      key = pkl_pkg::KEY_W'($urandom);
    else
      key = key_pool[$urandom_range(KEY_POOL-1)];
    send_item(cmd, key);
  endtask

  task automatic run_phase(input int count, input int idle, input int stall);
    idle_pct = idle;
    stall_pct <= stall;
    repeat (count)
      send_random();
  endtask

  initial begin
    int waited;
    int i;
    key_pool[0] = KEY_MAX;
    key_pool[1] = pkl_pkg::KEY_W'(1);
    for (i = 2; i < KEY_POOL; i++) begin
      key_pool[i] = pkl_pkg::KEY_W'($urandom);
      if (key_pool[i] == '0)
        key_pool[i] = pkl_pkg::KEY_W'(i);
    end
    repeat (10)
      @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, duplicates, key zero, unused command, full list
    send_item(pkl_pkg::CMD_CHECK, pkl_pkg::KEY_W'(5));
    send_item(pkl_pkg::CMD_PUT, KEY_MAX);
    send_item(pkl_pkg::CMD_PUT, KEY_MAX);
    send_item(pkl_pkg::CMD_PUT, '0);
    send_item(pkl_pkg::CMD_CHECK, '0);
    send_item(pkl_pkg::CMD_DEL, '0);
    send_item(CMD_UNUSED, KEY_MAX);
    send_item(pkl_pkg::CMD_DEL, key_pool[3]);
    for (i = 1; i < LIST_DEPTH; i++)
      send_item(pkl_pkg::CMD_PUT, key_pool[i]);
    send_item(pkl_pkg::CMD_PUT, key_pool[LIST_DEPTH]);
    send_item(pkl_pkg::CMD_CHECK, key_pool[LIST_DEPTH-1]);
    send_item(pkl_pkg::CMD_DEL, key_pool[LIST_DEPTH-1]);
    send_item(pkl_pkg::CMD_DEL, key_pool[8]);
    send_item(pkl_pkg::CMD_DEL, KEY_MAX);

    run_phase(130, 0, 0);
    // long receiver hold while the sender keeps offering, so the input backs up
    hold_reqs <= hold_reqs + 1;
    repeat (20)
      send_random();
    run_phase(130, 77, 0);
    run_phase(130, 0, 77);
    run_phase(130, 6, 6);

    in_valid  <= 1'b0;
    stall_pct <= 0;
    @(posedge clk);
    waited = 0;
    while (outstanding != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10)
      @(posedge clk);
    if (outstanding != 0)
      $error("%0d expected results never arrived", outstanding);

    $display("%0d commands sent: %0d found or removed, %0d inserted, %0d list full,",
             sent, n_found, n_inserted, n_full);
    $display("%0d not found; idle mixes: none, sender only, receiver only, both light;",
             n_missed);
    $display("one long output hold");
    if (errors == 0 && outstanding == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- packed_key_list_engine.f -----
hdl/pkl_pkg.sv
hdl/pkl_cell.sv
hdl/pkl_hit_enc.sv
hdl/packed_key_list_engine.sv
sim/pkl_checker.sv
sim/packed_key_list_engine_test.sv
